@@ design/alidm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alidm_pkg
// Request codes, status codes and sequencer states of the array list block.
// ----------------------------------------------------------------------------
package alidm_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_DUMP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_WINIT,
    S_WALK,
    S_REPORT,
    S_DREAD,
    S_DEMIT
  } state_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned CountW = 7;

endpackage

@@ design/alidm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alidm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module alidm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/array_list_insert_delete_minmax.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_minmax
// Ordered list of signed 32-bit values with positional insert and delete,
// append and in-order dump; each result reports count, largest and smallest.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid_i, in_stall_o | req_type_i, pos_i, value_i
//  out     | out_valid_o, out_stall_i | status_o, count_o, element_o, largest_o,
//          |                        | smallest_o, last_o
//
// One transaction at a time; in_stall_o is high from acceptance until the last
// result is loaded into the output register. Append writes its value on
// acceptance; insert or delete first moves each shifted entry with one RAM read
// and one write, then every request runs a min/max walk of one RAM read per
// entry, and a dump then reads and emits each entry in order through the single
// registered-read RAM port. Output stalls hold the sequencer. Reset empties the list; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module array_list_insert_delete_minmax
  import alidm_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic [PosW-1:0]          pos_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [CountW-1:0]        count_o,
  output logic signed [ValueW-1:0] element_o,
  output logic signed [ValueW-1:0] largest_o,
  output logic signed [ValueW-1:0] smallest_o,
  output logic                     last_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > PosW) ? CW : PosW) + 1;

  state_e                   state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [AW-1:0]            addr_q, addr_d;
  logic [AW-1:0]            end_q, end_d;
  logic [AW-1:0]            wptr_q, wptr_d;
  logic                     pend_q, pend_d;
  logic                     rdone_q, rdone_d;
  logic                     first_q, first_d;
  req_e                     req_q, req_d;
  status_e                  status_q, status_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic signed [ValueW-1:0] max_q, max_d;
  logic signed [ValueW-1:0] min_q, min_d;

  logic                     ovalid_q, ovalid_d;
  status_e                  ostatus_q, ostatus_d;
  logic [CountW-1:0]        ocount_q, ocount_d;
  logic signed [ValueW-1:0] oelem_q, oelem_d;
  logic signed [ValueW-1:0] omax_q, omax_d;
  logic signed [ValueW-1:0] omin_q, omin_d;
  logic                     olast_q, olast_d;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr;
  logic [ValueW-1:0]        ram_wdata;
  logic [ValueW-1:0]        ram_rdata;
  logic signed [ValueW-1:0] rd_s;

  logic          acc, out_free, full, is_ins, last_idx;
  logic [XW-1:0] pos_x, cnt_x;
  logic          ins_bad, ins_tail, del_empty, del_bad, del_tail;
  logic [AW-1:0] cnt_m1;

  assign acc       = (state_q == S_IDLE) && in_valid_i;
  assign out_free  = !ovalid_q || !out_stall_i;
  assign full      = (cnt_q == CW'(CAPACITY));
  assign pos_x     = XW'(pos_i);
  assign cnt_x     = XW'(cnt_q);
  assign ins_bad   = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
  assign ins_tail  = (pos_x == cnt_x + XW'(1));
  assign del_empty = (cnt_q == '0);
  assign del_bad   = (pos_x == '0) || (pos_x > cnt_x);
  assign del_tail  = (pos_x == cnt_x);
  assign cnt_m1    = AW'(cnt_q - CW'(1));
  assign is_ins    = (req_q == REQ_INSERT);
  assign last_idx  = (addr_q == cnt_m1);
  assign rd_s      = $signed(ram_rdata);

  alidm_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (req_e'(req_type_i))
            REQ_INSERT: begin
              state_d = (ins_bad || full || ins_tail) ? S_WINIT : S_SHIFT;
            end
            REQ_DELETE: begin
              state_d = (del_empty || del_bad || del_tail) ? S_WINIT : S_SHIFT;
            end
            default: state_d = S_WINIT;
          endcase
        end
      end
      S_SHIFT: begin
        if (rdone_q) begin
          state_d = is_ins ? S_PUT : S_WINIT;
        end
      end
      S_PUT:   state_d = S_WINIT;
      S_WINIT: state_d = S_WALK;
      S_WALK: begin
        if (cnt_q == '0 || rdone_q) begin
          state_d = (req_q == REQ_DUMP && cnt_q != '0) ? S_DREAD : S_REPORT;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DREAD: state_d = S_DEMIT;
      S_DEMIT: begin
        if (out_free) begin
          state_d = last_idx ? S_IDLE : S_DREAD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    end_d     = end_q;
    wptr_d    = wptr_q;
    pend_d    = pend_q;
    rdone_d   = rdone_q;
    first_d   = first_q;
    req_d     = req_q;
    status_d  = status_q;
    val_d     = val_q;
    max_d     = max_q;
    min_d     = min_q;
    ovalid_d  = ovalid_q && out_stall_i;
    ostatus_d = ostatus_q;
    ocount_d  = ocount_q;
    oelem_d   = oelem_q;
    omax_d    = omax_q;
    omin_d    = omin_q;
    olast_d   = olast_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = wptr_q;
    ram_wdata = ram_rdata;
    in_stall_o = (state_q != S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          req_d    = req_e'(req_type_i);
          val_d    = value_i;
          status_d = ST_OK;
          pend_d   = 1'b0;
          rdone_d  = 1'b0;
          case (req_e'(req_type_i))
            REQ_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_q);
                ram_wdata = value_i;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            REQ_INSERT: begin
              if (ins_bad) begin
                status_d = ST_BADPOS;
              end else if (full) begin
                status_d = ST_FULL;
              end else if (ins_tail) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_q);
                ram_wdata = value_i;
                cnt_d     = cnt_q + CW'(1);
              end else begin
                addr_d = cnt_m1;
                end_d  = AW'(pos_x - XW'(1));
              end
            end
            REQ_DELETE: begin
              if (del_empty) begin
                status_d = ST_EMPTY;
              end else if (del_bad) begin
                status_d = ST_BADPOS;
              end else if (del_tail) begin
                cnt_d = cnt_q - CW'(1);
              end else begin
                addr_d = AW'(pos_x);
                end_d  = cnt_m1;
              end
            end
            default: begin
              if (del_empty) begin
                status_d = ST_EMPTY;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (!rdone_q) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          wptr_d = is_ins ? addr_q + AW'(1) : addr_q - AW'(1);
          if (addr_q == end_q) begin
            rdone_d = 1'b1;
          end else begin
            addr_d = is_ins ? addr_q - AW'(1) : addr_q + AW'(1);
          end
        end
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (rdone_q && !is_ins) begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = end_q;
        ram_wdata = val_q;
        cnt_d     = cnt_q + CW'(1);
      end
      S_WINIT: begin
        addr_d  = '0;
        pend_d  = 1'b0;
        rdone_d = 1'b0;
        first_d = 1'b1;
        max_d   = '0;
        min_d   = '0;
      end
      S_WALK: begin
        if (cnt_q != '0) begin
          if (!rdone_q) begin
            ram_re = 1'b1;
            pend_d = 1'b1;
            if (last_idx) begin
              rdone_d = 1'b1;
            end else begin
              addr_d = addr_q + AW'(1);
            end
          end
          if (pend_q) begin
            first_d = 1'b0;
            if (first_q || rd_s > max_q) begin
              max_d = rd_s;
            end
            if (first_q || rd_s < min_q) begin
              min_d = rd_s;
            end
          end
          if (rdone_q) begin
            addr_d = '0;
          end
        end
      end
      S_REPORT: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          ocount_d  = CountW'(cnt_q);
          oelem_d   = '0;
          omax_d    = max_q;
          omin_d    = min_q;
          olast_d   = 1'b1;
        end
      end
      S_DREAD: begin
        ram_re = 1'b1;
      end
      S_DEMIT: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = ST_OK;
          ocount_d  = CountW'(cnt_q);
          oelem_d   = rd_s;
          omax_d    = max_q;
          omin_d    = min_q;
          olast_d   = last_idx;
          addr_d    = addr_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
      rdone_q  <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      pend_q   <= pend_d;
      rdone_q  <= rdone_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    end_q     <= end_d;
    wptr_q    <= wptr_d;
    req_q     <= req_d;
    status_q  <= status_d;
    val_q     <= val_d;
    max_q     <= max_d;
    min_q     <= min_d;
    ostatus_q <= ostatus_d;
    ocount_q  <= ocount_d;
    oelem_q   <= oelem_d;
    omax_q    <= omax_d;
    omin_q    <= omin_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = ostatus_q;
  assign count_o     = ocount_q;
  assign element_o   = oelem_q;
  assign largest_o   = omax_q;
  assign smallest_o  = omin_q;
  assign last_o      = olast_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_type_i == REQ_APPEND && !full) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("append did not grow the list");

  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(largest_o < smallest_o))
    else $error("largest below smallest");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && pend_q) |-> (XW'(wptr_q) <= cnt_x))
    else $error("shift write outside the list");
`endif

endmodule

@@ tb/alidm_list_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alidm_list_checker
// Watches both channels of the array list block. Every accepted request
// updates a local copy of the list and queues the results it must cause;
// every accepted result is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module alidm_list_checker
  import alidm_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               req_type_i,
  input  logic [PosW-1:0]          pos_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [1:0]               status_i,
  input  logic [CountW-1:0]        count_i,
  input  logic signed [ValueW-1:0] element_i,
  input  logic signed [ValueW-1:0] largest_i,
  input  logic signed [ValueW-1:0] smallest_i,
  input  logic                     last_i,
  output int unsigned              errors_o,
  output int unsigned              pending_o
);

  typedef struct packed {
    status_e                  status;
    logic [CountW-1:0]        count;
    logic signed [ValueW-1:0] element;
    logic signed [ValueW-1:0] largest;
    logic signed [ValueW-1:0] smallest;
    logic                     last;
  } list_result_t;

  logic signed [ValueW-1:0] list_q[$];
  list_result_t             results_q[$];
  int unsigned              n_errors = 0;

  task automatic queue_result(status_e st, logic signed [ValueW-1:0] elem, logic is_last);
    list_result_t             r;
    logic signed [ValueW-1:0] hi;
    logic signed [ValueW-1:0] lo;
    hi = '0;
    lo = '0;
    if (list_q.size() != 0) begin
      hi = list_q[0];
      lo = list_q[0];
      foreach (list_q[k]) begin
        if (list_q[k] > hi) hi = list_q[k];
        if (list_q[k] < lo) lo = list_q[k];
      end
    end
    r.status   = st;
    r.count    = CountW'(list_q.size());
    r.element  = elem;
    r.largest  = hi;
    r.smallest = lo;
    r.last     = is_last;
    results_q.push_back(r);
  endtask

  task automatic apply_request(req_e req, logic [PosW-1:0] pos,
                               logic signed [ValueW-1:0] val);
    int      p;
    int      n;
    status_e st;
    p  = pos;
    n  = list_q.size();
    st = ST_OK;
    case (req)
      REQ_APPEND: begin
        if (n >= CAPACITY) st = ST_FULL;
        else list_q.push_back(val);
      end
      REQ_INSERT: begin
        if (p < 1 || p > n + 1) st = ST_BADPOS;
        else if (n >= CAPACITY) st = ST_FULL;
        else list_q.insert(p - 1, val);
      end
      REQ_DELETE: begin
        if (n == 0) st = ST_EMPTY;
        else if (p < 1 || p > n) st = ST_BADPOS;
        else list_q.delete(p - 1);
      end
      default: ;
    endcase
    if (req == REQ_DUMP) begin
      if (n == 0) begin
        queue_result(ST_EMPTY, '0, 1'b1);
      end else begin
        for (int k = 0; k < n; k++) queue_result(ST_OK, list_q[k], k == n - 1);
      end
    end else begin
      queue_result(st, '0, 1'b1);
    end
  endtask

  task automatic check_field(string name, longint expv, longint gotv);
    if (expv != gotv) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, gotv);
    end
  endtask

  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) apply_request(req_e'(req_type_i), pos_i, value_i);
      if (out_valid_i && !out_stall_i) begin
        if (results_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected transaction, expected none, actual status %0d count %0d",
                   $time, status_i, count_i);
        end else begin
          exp_r = results_q.pop_front();
          check_field("status", exp_r.status, status_i);
          check_field("count", exp_r.count, count_i);
          check_field("element", $signed(exp_r.element), element_i);
          check_field("largest", $signed(exp_r.largest), largest_i);
          check_field("smallest", $signed(exp_r.smallest), smallest_i);
          check_field("last", exp_r.last, last_i);
        end
      end
    end
    errors_o  <= n_errors;
    pending_o <= results_q.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the array list block: directed corner requests,
// then random phases that fill the list, hit the full and empty limits and
// mix all requests, with random gaps on both sides and a long output hold.
// ----------------------------------------------------------------------------
module tb;
  import alidm_pkg::*;

  localparam int unsigned Capacity      = 64;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned EndCycles     = 3 * Capacity + 10;
  localparam int unsigned TimeoutCycles = 4_000_000;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [1:0]               req_type   = REQ_APPEND;
  logic [PosW-1:0]          pos        = '0;
  logic signed [ValueW-1:0] value      = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [1:0]               status;
  logic [CountW-1:0]        count;
  logic signed [ValueW-1:0] element;
  logic signed [ValueW-1:0] largest;
  logic signed [ValueW-1:0] smallest;
  logic                     last;
  int unsigned              errors;
  int unsigned              pending;

  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned hold_reqs  = 0;
  int          list_len   = 0;
  int unsigned cycles     = 0;

  array_list_insert_delete_minmax #(
    .CAPACITY (Capacity)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .pos_i       (pos),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .count_o     (count),
    .element_o   (element),
    .largest_o   (largest),
    .smallest_o  (smallest),
    .last_o      (last)
  );

  alidm_list_checker #(
    .CAPACITY (Capacity)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .req_type_i  (req_type),
    .pos_i       (pos),
    .value_i     (value),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .status_i    (status),
    .count_i     (count),
    .element_i   (element),
    .largest_i   (largest),
    .smallest_i  (smallest),
    .last_i      (last),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= TimeoutCycles) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // mostly short, now and then long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  initial begin : rx_side
    int unsigned hold_seen;
    int          stall_left;
    hold_seen  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen  = hold_reqs;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_len();
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(req_e req, int p, logic [ValueW-1:0] val);
    int gap;
    req_type <= req;
    pos      <= p[PosW-1:0];
    value    <= val;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (req)
      REQ_APPEND: if (list_len < Capacity) list_len++;
      REQ_INSERT: if (p >= 1 && p <= list_len + 1 && list_len < Capacity) list_len++;
      REQ_DELETE: if (list_len > 0 && p >= 1 && p <= list_len) list_len--;
      default: ;
    endcase
    gap = (tx_idle_en && $urandom_range(0, 1) == 0) ? pick_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic rand_req(int grow_pct);
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_req(REQ_DUMP, $urandom_range(0, 127), rand_value());
    end else if (r < 6 + grow_pct) begin
      if ($urandom_range(0, 1) == 0) begin
        send_req(REQ_APPEND, $urandom_range(0, 127), rand_value());
      end else begin
        if ($urandom_range(0, 9) == 0) p = ($urandom_range(0, 1) == 0) ? 0 :
                                            $urandom_range(list_len + 2, 127);
        else p = $urandom_range(1, list_len + 1);
        send_req(REQ_INSERT, p, rand_value());
      end
    end else begin
      if (list_len == 0) p = $urandom_range(0, 127);
      else if ($urandom_range(0, 9) == 0) p = ($urandom_range(0, 1) == 0) ? 0 :
                                               $urandom_range(list_len + 1, 127);
      else p = $urandom_range(1, list_len);
      send_req(REQ_DELETE, p, rand_value());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;

    // empty list corners, then position limits on a short list
    send_req(REQ_DUMP, 0, '0);
    send_req(REQ_DELETE, 1, '0);
    send_req(REQ_DELETE, 127, '1);
    send_req(REQ_INSERT, 0, 32'd1);
    send_req(REQ_INSERT, 2, 32'd1);
    send_req(REQ_APPEND, 0, 32'h7FFF_FFFF);
    send_req(REQ_APPEND, 127, 32'h8000_0000);
    send_req(REQ_INSERT, 1, '0);
    send_req(REQ_INSERT, 4, '1);
    send_req(REQ_INSERT, 2, 32'd5);
    send_req(REQ_INSERT, 7, 32'd9);
    send_req(REQ_DELETE, 0, '0);
    send_req(REQ_DELETE, 6, '0);
    send_req(REQ_DELETE, 5, '0);
    send_req(REQ_DELETE, 1, '0);
    send_req(REQ_DUMP, 127, '1);
    send_req(REQ_APPEND, 64, 32'h5555_5555);
    send_req(REQ_APPEND, 1, 32'hAAAA_AAAA);
    send_req(REQ_DUMP, 3, '0);
    wait_drained();

    // back to back up to a full list, then the full list corners
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    while (list_len < Capacity) rand_req(88);
    send_req(REQ_APPEND, 0, rand_value());
    send_req(REQ_INSERT, $urandom_range(1, Capacity + 1), rand_value());
    send_req(REQ_INSERT, Capacity + 2, rand_value());
    send_req(REQ_DUMP, 0, '0);
    send_req(REQ_DELETE, Capacity + 1, '0);
    send_req(REQ_DELETE, Capacity, '0);
    send_req(REQ_INSERT, Capacity, rand_value());

    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    repeat (40) rand_req(50);
    wait_drained();

    // long output hold while requests keep coming
    tx_idle_en = 1'b0;
    hold_reqs <= hold_reqs + 1;
    repeat (12) rand_req(50);
    tx_idle_en = 1'b1;
    repeat (30) rand_req(50);

    while (list_len != 0) rand_req(15);
    send_req(REQ_DELETE, $urandom_range(0, 127), rand_value());
    send_req(REQ_DUMP, 0, '0);
    repeat (20) rand_req(55);

    wait_drained();
    repeat (EndCycles) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
